[rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// Text console writer package
// Shared constants, request codes and sequencer states for the text console.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Default screen geometry.
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Field widths of the request and result ports.
  localparam int REQ_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int ENTRY_W = 16;
  localparam int POS_W   = 11;

  // Character codes with special handling.
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CRETURN = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BACKSP  = 8'h08;

  // A tab prints four spaces: one now and this many more.
  localparam logic [1:0] TAB_EXTRA = 2'd3;

  // Attribute byte after reset.
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RST = 8'h07;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUT   = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PRINT,
    ST_BLANK_CUR,
    ST_SCROLL,
    ST_BLANK_ROW,
    ST_FINISH
  } state_t;

endpackage

[rtl/text_console_writer_top.sv]
// ----------------------------------------------------------------------------
// Text console writer
// A request is taken only while busy is low; a scroll or a clear sweeps the
// screen through the one memory port. The next request can be taken at the
// edge that takes done, and done cannot be stalled.
// After reset a clearing pass over every cell keeps busy high.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [tcw_pkg::REQ_W-1:0]    req_type,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
  input  logic [tcw_pkg::COLOR_W-1:0]  cell_color,
  input  logic [tcw_pkg::ROW_W-1:0]    cell_row,
  input  logic [tcw_pkg::COL_W-1:0]    cell_col,
  input  logic                         cfg_we,
  input  logic [tcw_pkg::COLOR_W-1:0]  cfg_wdata,
  output logic                         done,
  output logic [tcw_pkg::ENTRY_W-1:0]  cell_entry,
  output logic [tcw_pkg::ROW_W-1:0]    cursor_row,
  output logic [tcw_pkg::COL_W-1:0]    cursor_col,
  output logic [tcw_pkg::POS_W-1:0]    cursor_position
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_SRC  = AW'(CELLS - COLUMNS);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);

  // Sequencer and datapath registers.
  state_t             state, state_next;
  logic [RW-1:0]      row_now, row_now_next;
  logic [CW-1:0]      col_now, col_now_next;
  logic [AW-1:0]      addr, addr_next;
  logic [AW-1:0]      wr_addr, wr_addr_next;
  logic               pend, pend_next;
  logic [1:0]         tab_left, tab_left_next;
  logic               resume, resume_next;
  logic [CHAR_W-1:0]  ch_reg, ch_reg_next;
  logic [COLOR_W-1:0] fill_color, fill_color_next;
  logic               clr_reply, clr_reply_next;
  logic               rd_sel, rd_sel_next;
  logic [COLOR_W-1:0] text_color;

  // Screen memory port.
  logic [ENTRY_W-1:0] mem [CELLS];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] rd_data;

  // Helper signals.
  logic               in_range;
  logic [AW-1:0]      in_addr;
  logic [AW-1:0]      cur_addr;
  logic               more;
  logic               finish;

  // Address of the requested cell and of the cursor cell.
  assign in_range = (32'(cell_row) < ROWS) && (32'(cell_col) < COLUMNS);
  assign in_addr  = AW'(32'(cell_row) * COLUMNS + 32'(cell_col));
  assign cur_addr = AW'(32'(row_now) * COLUMNS + 32'(col_now));

  assign busy = (state != ST_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control and cursor registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_now    <= '0;
      col_now    <= '0;
      addr       <= '0;
      pend       <= 1'b0;
      tab_left   <= '0;
      resume     <= 1'b0;
      fill_color <= TEXT_COLOR_RST;
      clr_reply  <= 1'b0;
      rd_sel     <= 1'b0;
    end else begin
      row_now    <= row_now_next;
      col_now    <= col_now_next;
      addr       <= addr_next;
      pend       <= pend_next;
      tab_left   <= tab_left_next;
      resume     <= resume_next;
      fill_color <= fill_color_next;
      clr_reply  <= clr_reply_next;
      rd_sel     <= rd_sel_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    wr_addr <= wr_addr_next;
    ch_reg  <= ch_reg_next;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= TEXT_COLOR_RST;
    end else if (cfg_we) begin
      text_color <= cfg_wdata;
    end
  end

  // Next state, memory port control and cursor updates.
  always_comb begin
    state_next      = state;
    row_now_next    = row_now;
    col_now_next    = col_now;
    addr_next       = addr;
    wr_addr_next    = wr_addr;
    pend_next       = pend;
    tab_left_next   = tab_left;
    resume_next     = resume;
    ch_reg_next     = ch_reg;
    fill_color_next = fill_color;
    clr_reply_next  = clr_reply;
    rd_sel_next     = rd_sel;
    mem_we          = 1'b0;
    mem_waddr       = cur_addr;
    mem_wdata       = {text_color, CH_SPACE};
    mem_re          = 1'b0;
    mem_raddr       = in_addr;
    more            = 1'b0;
    finish          = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          rd_sel_next = 1'b0;
          unique case (req_t'(req_type))
            REQ_PUT: begin
              priority if (char_code == CH_NEWLINE) begin
                col_now_next = '0;
                if (row_now == LAST_ROW) begin
                  addr_next   = '0;
                  pend_next   = 1'b0;
                  resume_next = 1'b0;
                  state_next  = ST_SCROLL;
                end else begin
                  row_now_next = row_now + RW'(1);
                  state_next   = ST_FINISH;
                end
              end else if (char_code == CH_CRETURN) begin
                col_now_next = '0;
                state_next   = ST_FINISH;
              end else if (char_code == CH_TAB) begin
                ch_reg_next   = CH_SPACE;
                tab_left_next = TAB_EXTRA;
                state_next    = ST_PRINT;
              end else if (char_code == CH_BACKSP) begin
                if (col_now != '0) begin
                  col_now_next = col_now - CW'(1);
                end else if (row_now != '0) begin
                  row_now_next = row_now - RW'(1);
                  col_now_next = LAST_COL;
                end
                state_next = ST_BLANK_CUR;
              end else begin
                ch_reg_next   = char_code;
                tab_left_next = '0;
                state_next    = ST_PRINT;
              end
            end
            REQ_WRITE: begin
              mem_we     = in_range;
              mem_waddr  = in_addr;
              mem_wdata  = {cell_color, char_code};
              state_next = ST_FINISH;
            end
            REQ_READ: begin
              mem_re      = in_range;
              rd_sel_next = in_range;
              state_next  = ST_FINISH;
            end
            REQ_CLEAR: begin
              fill_color_next = text_color;
              clr_reply_next  = 1'b1;
              addr_next       = '0;
              state_next      = ST_CLEAR;
            end
          endcase
        end
      end

      // Sweep the whole screen with blanks, cursor home at the end.
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr;
        mem_wdata = {fill_color, CH_SPACE};
        addr_next = addr + AW'(1);
        if (addr == LAST_CELL) begin
          row_now_next = '0;
          col_now_next = '0;
          state_next   = clr_reply ? ST_FINISH : ST_IDLE;
        end
      end

      // Print one byte at the cursor and advance it.
      ST_PRINT: begin
        mem_we        = 1'b1;
        mem_wdata     = {text_color, ch_reg};
        more          = (tab_left != '0);
        tab_left_next = tab_left - {1'b0, more};
        resume_next   = more;
        if (col_now == LAST_COL) begin
          col_now_next = '0;
          if (row_now == LAST_ROW) begin
            addr_next  = '0;
            pend_next  = 1'b0;
            state_next = ST_SCROLL;
          end else begin
            row_now_next = row_now + RW'(1);
            state_next   = more ? ST_PRINT : ST_FINISH;
          end
        end else begin
          col_now_next = col_now + CW'(1);
          state_next   = more ? ST_PRINT : ST_FINISH;
        end
      end

      // Blank the cell under the cursor after a backspace.
      ST_BLANK_CUR: begin
        mem_we     = 1'b1;
        state_next = ST_FINISH;
      end

      // Copy each cell from one row below; the read of one cell overlaps the
      // write of the one before it.
      ST_SCROLL: begin
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr;
          mem_wdata = rd_data;
        end
        if (addr == LAST_SRC) begin
          pend_next  = 1'b0;
          state_next = ST_BLANK_ROW;
        end else begin
          mem_re       = 1'b1;
          mem_raddr    = AW'(32'(addr) + COLUMNS);
          wr_addr_next = addr;
          pend_next    = 1'b1;
          addr_next    = addr + AW'(1);
        end
      end

      // Blank the bottom row, then resume a pending tab.
      ST_BLANK_ROW: begin
        mem_we    = 1'b1;
        mem_waddr = addr;
        addr_next = addr + AW'(1);
        if (addr == LAST_CELL) begin
          state_next = resume ? ST_PRINT : ST_FINISH;
        end
      end

      ST_FINISH: begin
        finish     = 1'b1;
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Screen memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // Result strobe and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      cell_entry      <= rd_sel ? rd_data : '0;
      cursor_row      <= ROW_W'(row_now);
      cursor_col      <= COL_W'(col_now);
      cursor_position <= POS_W'(cur_addr);
    end
  end

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// Text console writer testbench
// Sends put-character, write-cell, read-cell and clear-screen requests to the
// console and predicts every cursor report, including the read data, from a
// private copy of the screen. A short directed run covers the control bytes,
// wrap-around and out-of-range cells. It is followed by random traffic in
// three phases with different sender gaps and several text attribute settings.
// ----------------------------------------------------------------------------
module tb;
  import tcw_pkg::*;

  localparam int COLS        = COLUMNS_DEF;
  localparam int ROWS        = ROWS_DEF;
  localparam int CELLS       = COLS * ROWS;
  localparam int TAB_CELLS   = 4;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_WAIT  = 16;
  localparam int PHASE_ITEMS = 310;
  localparam int COLOR_EVERY = 100;

  // One expected cursor report.
  typedef struct {
    logic [ENTRY_W-1:0] entry;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [POS_W-1:0]   pos;
  } cursor_report_t;

  // Screen shadow and queue of cursor reports still to arrive.
  class console_scoreboard;
    logic [ENTRY_W-1:0] cells [CELLS];
    int unsigned        cur_row;
    int unsigned        cur_col;
    logic [COLOR_W-1:0] attr;
    cursor_report_t     pending [$];
    int                 mismatches;
    int                 checked;
    int                 scrolls;
    int                 req_count [4];

    function new();
      int i;
      attr = TEXT_COLOR_RST;
      for (i = 0; i < CELLS; i++) cells[i] = {TEXT_COLOR_RST, CH_SPACE};
      cur_row = 0;
      cur_col = 0;
      mismatches = 0;
      checked = 0;
      scrolls = 0;
      for (i = 0; i < 4; i++) req_count[i] = 0;
    endfunction

    function void set_attr(logic [COLOR_W-1:0] value);
      attr = value;
    endfunction

    // Move every row up by one and blank the bottom row.
    function void scroll_up();
      int i;
      for (i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
      for (i = CELLS - COLS; i < CELLS; i++) cells[i] = {attr, CH_SPACE};
      scrolls++;
    endfunction

    function void next_row();
      cur_row++;
      if (cur_row >= ROWS) begin
        scroll_up();
        cur_row = ROWS - 1;
      end
    endfunction

    function void print_byte(logic [CHAR_W-1:0] ch);
      cells[cur_row * COLS + cur_col] = {attr, ch};
      cur_col++;
      if (cur_col >= COLS) begin
        cur_col = 0;
        next_row();
      end
    endfunction

    function void put_char(logic [CHAR_W-1:0] ch);
      case (ch)
        CH_NEWLINE: begin
          cur_col = 0;
          next_row();
        end
        CH_CRETURN: cur_col = 0;
        CH_TAB: repeat (TAB_CELLS) print_byte(CH_SPACE);
        CH_BACKSP: begin
          // Step back, wrapping to the end of the previous row; the home
          // position stays put. The landing cell is blanked either way.
          if (cur_col > 0) begin
            cur_col--;
          end else if (cur_row > 0) begin
            cur_row--;
            cur_col = COLS - 1;
          end
          cells[cur_row * COLS + cur_col] = {attr, CH_SPACE};
        end
        default: print_byte(ch);
      endcase
    endfunction

    // Apply one accepted request and queue the report it must produce.
    function void log_request(req_t req, logic [CHAR_W-1:0] ch,
                              logic [COLOR_W-1:0] color, logic [ROW_W-1:0] row,
                              logic [COL_W-1:0] col);
      cursor_report_t exp;
      bit             in_range;
      int             i;
      in_range = (row < ROWS) && (col < COLS);
      exp.entry = '0;
      case (req)
        REQ_PUT: put_char(ch);
        REQ_WRITE: if (in_range) cells[row * COLS + col] = {color, ch};
        REQ_READ: if (in_range) exp.entry = cells[row * COLS + col];
        REQ_CLEAR: begin
          for (i = 0; i < CELLS; i++) cells[i] = {attr, CH_SPACE};
          cur_row = 0;
          cur_col = 0;
        end
        default: ;
      endcase
      exp.row = ROW_W'(cur_row);
      exp.col = COL_W'(cur_col);
      exp.pos = POS_W'(cur_row * COLS + cur_col);
      pending.push_back(exp);
      req_count[req]++;
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    // Compare one cursor report with the oldest expectation.
    task check_report(logic [ENTRY_W-1:0] entry, logic [ROW_W-1:0] row,
                      logic [COL_W-1:0] col, logic [POS_W-1:0] pos);
      cursor_report_t exp;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("report with no request pending (entry %h row %0d col %0d)",
                                  entry, row, col));
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (entry !== exp.entry)
        report_mismatch($sformatf("cell_entry %h, expected %h", entry, exp.entry));
      if (row !== exp.row)
        report_mismatch($sformatf("cursor_row %0d, expected %0d", row, exp.row));
      if (col !== exp.col)
        report_mismatch($sformatf("cursor_col %0d, expected %0d", col, exp.col));
      if (pos !== exp.pos)
        report_mismatch($sformatf("cursor_position %0d, expected %0d", pos, exp.pos));
    endtask

    task flush_leftovers();
      while (pending.size() != 0) begin
        void'(pending.pop_front());
        report_mismatch("request never answered");
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [REQ_W-1:0]    req_type = '0;
  logic [CHAR_W-1:0]   char_code = '0;
  logic [COLOR_W-1:0]  cell_color = '0;
  logic [ROW_W-1:0]    cell_row = '0;
  logic [COL_W-1:0]    cell_col = '0;
  logic                cfg_we = 1'b0;
  logic [COLOR_W-1:0]  cfg_wdata = '0;
  logic                done;
  logic [ENTRY_W-1:0]  cell_entry;
  logic [ROW_W-1:0]    cursor_row;
  logic [COL_W-1:0]    cursor_col;
  logic [POS_W-1:0]    cursor_position;

  console_scoreboard sb;
  int                idle_pct = 0;
  int                stall_cycles = 0;
  int                color_writes = 0;

  text_console_writer_top dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .req_type        (req_type),
    .char_code       (char_code),
    .cell_color      (cell_color),
    .cell_row        (cell_row),
    .cell_col        (cell_col),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .done            (done),
    .cell_entry      (cell_entry),
    .cursor_row      (cursor_row),
    .cursor_col      (cursor_col),
    .cursor_position (cursor_position)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every done strobe carries one cursor report.
  always @(posedge clk) begin
    if (!rst && done) sb.check_report(cell_entry, cursor_row, cursor_col, cursor_position);
  end

  // Watchdog: give up when no transaction moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles", STALL_LIMIT);
      $display("[text_console_writer_top] ERROR");
      $finish;
    end
  end

  // Present one request, with random sender gaps, until it is accepted.
  task automatic send_request(req_t req, logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] color,
                              logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    req_type   <= req;
    char_code  <= ch;
    cell_color <= color;
    cell_row   <= row;
    cell_col   <= col;
    do @(posedge clk); while (busy);
    sb.log_request(req, ch, color, row, col);
  endtask

  // Change the text attribute once the console has gone quiet.
  task automatic set_text_color(logic [COLOR_W-1:0] value);
    start <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0 || busy);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_attr(value);
    color_writes++;
  endtask

  task automatic put(logic [CHAR_W-1:0] ch);
    send_request(REQ_PUT, ch, '0, '0, '0);
  endtask

  // Random request: mostly text with control bytes, then cell writes and
  // reads that mostly land on the screen, and a rare clear.
  task automatic send_random_item();
    int                 pick;
    int                 kind;
    logic [CHAR_W-1:0]  ch;
    logic [COLOR_W-1:0] color;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    pick  = $urandom_range(999);
    kind  = $urandom_range(99);
    ch    = CHAR_W'($urandom_range(255));
    color = COLOR_W'($urandom_range(255));
    row   = ROW_W'($urandom_range(31));
    col   = COL_W'($urandom_range(127));
    if (pick < 690) begin
      if (kind < 14) ch = CH_NEWLINE;
      else if (kind < 18) ch = CH_CRETURN;
      else if (kind < 24) ch = CH_TAB;
      else if (kind < 34) ch = CH_BACKSP;
      else if (kind < 85) ch = CHAR_W'($urandom_range(8'h7E, 8'h20));
      send_request(REQ_PUT, ch, color, row, col);
    end else if (pick < 997) begin
      if (kind < 80) begin
        row = ROW_W'($urandom_range(ROWS - 1));
        col = COL_W'($urandom_range(COLS - 1));
        // Reads often look at the cursor row to catch scroll and wrap damage.
        if (pick >= 810 && kind < 40) row = ROW_W'(sb.cur_row);
      end
      if (pick < 810) send_request(REQ_WRITE, ch, color, row, col);
      else send_request(REQ_READ, ch, color, row, col);
    end else begin
      send_request(REQ_CLEAR, ch, color, row, col);
    end
  endtask

  initial begin
    int phase;
    int n;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // Let the power-up clearing pass finish before touching anything.
    do @(posedge clk); while (busy);

    // Directed part at the reset attribute.
    send_request(REQ_READ, '0, '0, '0, '0);
    put(8'h41);
    put(8'h00);
    put(8'hFF);
    put(CH_CRETURN);
    put(CH_TAB);
    put(CH_BACKSP);
    put(CH_NEWLINE);
    // Backspace from the start of a row wraps to the end of the row above,
    // and printing in the last column wraps forward again.
    put(CH_BACKSP);
    put(8'h7E);
    send_request(REQ_WRITE, 8'hFF, 8'hFF, 5'(ROWS - 1), 7'(COLS - 1));
    send_request(REQ_READ, '0, '0, 5'(ROWS - 1), 7'(COLS - 1));
    send_request(REQ_WRITE, 8'h00, 8'h00, '0, '0);
    send_request(REQ_READ, '0, '0, '0, '0);
    // Out-of-range cells: writes are dropped and reads return zero.
    send_request(REQ_WRITE, 8'h55, 8'hAA, 5'(ROWS), '0);
    send_request(REQ_WRITE, 8'h55, 8'hAA, '1, '1);
    send_request(REQ_READ, '0, '0, 5'(ROWS), '0);
    send_request(REQ_READ, '0, '0, '0, 7'(COLS));
    send_request(REQ_READ, '0, '0, '1, '1);
    send_request(REQ_CLEAR, '0, '0, '0, '0);
    // Backspace at home stays there but still blanks the cell.
    put(CH_BACKSP);
    send_request(REQ_READ, '0, '0, '0, '0);

    // Random phases: sender gaps of 36, then 87, then 0 percent.
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 36 : (phase == 1) ? 87 : 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % COLOR_EVERY == 0) begin
          if (phase == 0 && n == 0) set_text_color(8'h00);
          else if (phase == 1 && n == 0) set_text_color(8'hFF);
          else set_text_color(COLOR_W'($urandom_range(255)));
        end
        send_random_item();
      end
    end

    // Drain the last reports, then watch for strays.
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    sb.flush_leftovers();

    $display("Checked %0d reports: %0d put, %0d write, %0d read, %0d clear requests",
             sb.checked, sb.req_count[REQ_PUT], sb.req_count[REQ_WRITE],
             sb.req_count[REQ_READ], sb.req_count[REQ_CLEAR]);
    $display("Screen scrolled %0d times across %0d text attribute settings",
             sb.scrolls, color_writes + 1);
    if (sb.mismatches == 0) begin
      $display("[text_console_writer_top] OK");
    end else begin
      $display("[text_console_writer_top] ERROR");
    end
    $finish;
  end
endmodule
